FILE: rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue: command kinds,
// result status codes, field widths and the sequencer state type.
// ---------------------------------------------------------------------------
package spq_pkg;

    // Field widths of the command and result ports
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int PORT_TAG_W = 16;
    localparam int SEV_W      = 32;
    localparam int ARR_W      = 32;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SERVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_SERVED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SCAN,
        ST_DRAIN,
        ST_REPLY
    } state_t;

endpackage

FILE: rtl/spq_slot_ram.sv
// ---------------------------------------------------------------------------
// spq_slot_ram
// Slot storage: one word per slot holding severity, arrival number and tag.
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module spq_slot_ram #(
    parameter int DEPTH = 64,
    parameter int TAG_W = 16
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  logic signed [spq_pkg::SEV_W-1:0] wr_sev,
    input  logic [spq_pkg::ARR_W-1:0]       wr_arr,
    input  logic [TAG_W-1:0]                wr_tag,
    input  logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic signed [spq_pkg::SEV_W-1:0] rd_sev,
    output logic [spq_pkg::ARR_W-1:0]       rd_arr,
    output logic [TAG_W-1:0]                rd_tag
);

    localparam int WORD_W = spq_pkg::SEV_W + spq_pkg::ARR_W + TAG_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_word_reg;

    // Write one slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_sev, wr_arr, wr_tag};
        end
    end

    // Read one slot, data valid the next cycle
    always_ff @(posedge clk)
    begin
        rd_word_reg <= mem[rd_addr];
    end

    assign rd_sev = signed'(rd_word_reg[WORD_W-1 -: spq_pkg::SEV_W]);
    assign rd_arr = rd_word_reg[TAG_W +: spq_pkg::ARR_W];
    assign rd_tag = rd_word_reg[TAG_W-1:0];

endmodule

FILE: rtl/spq_rank_cmp.sv
// ---------------------------------------------------------------------------
// spq_rank_cmp
// Ranking comparator: decides whether a candidate slot is served
// before the current best (higher severity, then earlier arrival).
// ---------------------------------------------------------------------------
module spq_rank_cmp (
    input  logic signed [spq_pkg::SEV_W-1:0] cand_sev,
    input  logic [spq_pkg::ARR_W-1:0]        cand_arr,
    input  logic signed [spq_pkg::SEV_W-1:0] best_sev,
    input  logic [spq_pkg::ARR_W-1:0]        best_arr,
    output logic                             ahead
);

    // Rank by severity, break ties by arrival order
    always_comb
    begin
        if (cand_sev != best_sev)
        begin
            ahead = (cand_sev > best_sev);
        end
        else
        begin
            ahead = (cand_arr < best_arr);
        end
    end

endmodule

FILE: rtl/stable_priority_queue.sv
// ---------------------------------------------------------------------------
// stable_priority_queue
// Bounded stable max-priority queue. Inserts stamp an arrival number; a
// serve removes the highest severity entry, earliest arrival first among
// equals; a clear empties the queue and restarts arrival numbering.
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+-----------------------------------------
//   command  | start / busy     | kind, entry_tag, entry_severity
//   result   | done (strobe)    | status, served_tag, served_severity
//
// Clear and kind 3 finish in idle with no done; serve on empty and insert on
// full are answered from idle. Insert runs a free slot search over the valid bits,
// one slot per cycle. Serve reads every slot: one slot RAM read and one
// comparator pass per slot, plus pipeline drain and reply.
// Reset empties the queue at once through the valid bits; no clearing pass.
// The result is a one-cycle done strobe; the receiver cannot stall it.
// ---------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [spq_pkg::KIND_W-1:0]          kind,
    input  logic [spq_pkg::PORT_TAG_W-1:0]      entry_tag,
    input  logic signed [spq_pkg::SEV_W-1:0]    entry_severity,
    output logic                                done,
    output logic [spq_pkg::STATUS_W-1:0]        status,
    output logic [spq_pkg::PORT_TAG_W-1:0]      served_tag,
    output logic signed [spq_pkg::SEV_W-1:0]    served_severity
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int TAG_W = (TAG_BITS < spq_pkg::PORT_TAG_W) ? TAG_BITS
                                                           : spq_pkg::PORT_TAG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

    // Control state
    spq_pkg::state_t             state_reg, state_next;
    logic [CAPACITY-1:0]         valid_reg, valid_next;
    logic [OCC_W-1:0]            occ_reg, occ_next;
    logic [spq_pkg::ARR_W-1:0]   arr_cnt_reg, arr_cnt_next;
    logic [IDX_W-1:0]            scan_idx_reg, scan_idx_next;
    logic                        rd_live_reg, rd_live_next;
    logic [IDX_W-1:0]            rd_idx_reg, rd_idx_next;
    logic                        best_found_reg, best_found_next;
    logic                        done_reg, done_next;

    // Payload state
    logic [spq_pkg::PORT_TAG_W-1:0]       in_tag_reg, in_tag_next;
    logic signed [spq_pkg::SEV_W-1:0]     in_sev_reg, in_sev_next;
    logic signed [spq_pkg::SEV_W-1:0]     best_sev_reg, best_sev_next;
    logic [spq_pkg::ARR_W-1:0]            best_arr_reg, best_arr_next;
    logic [TAG_W-1:0]                     best_tag_reg, best_tag_next;
    logic [IDX_W-1:0]                     best_idx_reg, best_idx_next;
    logic [spq_pkg::STATUS_W-1:0]         status_reg, status_next;
    logic [spq_pkg::PORT_TAG_W-1:0]       served_tag_reg, served_tag_next;
    logic signed [spq_pkg::SEV_W-1:0]     served_sev_reg, served_sev_next;

    // Slot RAM and comparator hookup
    logic                              ram_wr_en;
    logic signed [spq_pkg::SEV_W-1:0]  ram_rd_sev;
    logic [spq_pkg::ARR_W-1:0]         ram_rd_arr;
    logic [TAG_W-1:0]                  ram_rd_tag;
    logic                              cand_ahead;

    spq_slot_ram #(
        .DEPTH (CAPACITY),
        .TAG_W (TAG_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (scan_idx_reg),
        .wr_sev  (in_sev_reg),
        .wr_arr  (arr_cnt_reg),
        .wr_tag  (in_tag_reg[TAG_W-1:0]),
        .rd_addr (scan_idx_reg),
        .rd_sev  (ram_rd_sev),
        .rd_arr  (ram_rd_arr),
        .rd_tag  (ram_rd_tag)
    );

    spq_rank_cmp u_rank_cmp (
        .cand_sev (ram_rd_sev),
        .cand_arr (ram_rd_arr),
        .best_sev (best_sev_reg),
        .best_arr (best_arr_reg),
        .ahead    (cand_ahead)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spq_pkg::ST_IDLE;
            valid_reg      <= '0;
            occ_reg        <= '0;
            arr_cnt_reg    <= '0;
            scan_idx_reg   <= '0;
            rd_live_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            best_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            arr_cnt_reg    <= arr_cnt_next;
            scan_idx_reg   <= scan_idx_next;
            rd_live_reg    <= rd_live_next;
            rd_idx_reg     <= rd_idx_next;
            best_found_reg <= best_found_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_tag_reg     <= in_tag_next;
        in_sev_reg     <= in_sev_next;
        best_sev_reg   <= best_sev_next;
        best_arr_reg   <= best_arr_next;
        best_tag_reg   <= best_tag_next;
        best_idx_reg   <= best_idx_next;
        status_reg     <= status_next;
        served_tag_reg <= served_tag_next;
        served_sev_reg <= served_sev_next;
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        arr_cnt_next    = arr_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        rd_live_next    = 1'b0;
        rd_idx_next     = scan_idx_reg;
        best_found_next = best_found_reg;
        done_next       = 1'b0;
        in_tag_next     = in_tag_reg;
        in_sev_next     = in_sev_reg;
        best_sev_next   = best_sev_reg;
        best_arr_next   = best_arr_reg;
        best_tag_next   = best_tag_reg;
        best_idx_next   = best_idx_reg;
        status_next     = status_reg;
        served_tag_next = served_tag_reg;
        served_sev_next = served_sev_reg;
        ram_wr_en       = 1'b0;

        // Fold the slot read last cycle into the running best
        if (rd_live_reg && (!best_found_reg || cand_ahead))
        begin
            best_found_next = 1'b1;
            best_sev_next   = ram_rd_sev;
            best_arr_next   = ram_rd_arr;
            best_tag_next   = ram_rd_tag;
            best_idx_next   = rd_idx_reg;
        end

        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    in_tag_next = entry_tag;
                    in_sev_next = entry_severity;
                    case (kind)
                        spq_pkg::KIND_INSERT:
                        begin
                            if (occ_reg == FULL_OCC)
                            begin
                                done_next       = 1'b1;
                                status_next     = spq_pkg::STATUS_FULL;
                                served_tag_next = '0;
                                served_sev_next = '0;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                state_next    = spq_pkg::ST_FIND;
                            end
                        end
                        spq_pkg::KIND_SERVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                done_next       = 1'b1;
                                status_next     = spq_pkg::STATUS_EMPTY;
                                served_tag_next = '0;
                                served_sev_next = '0;
                            end
                            else
                            begin
                                scan_idx_next   = '0;
                                best_found_next = 1'b0;
                                state_next      = spq_pkg::ST_SCAN;
                            end
                        end
                        spq_pkg::KIND_CLEAR:
                        begin
                            valid_next   = '0;
                            occ_next     = '0;
                            arr_cnt_next = '0;
                        end
                        default:
                        begin
                            // Unused kind: drop
                        end
                    endcase
                end
            end

            spq_pkg::ST_FIND:
            begin
                // Take the first free slot, else advance
                if (!valid_reg[scan_idx_reg])
                begin
                    ram_wr_en                = 1'b1;
                    valid_next[scan_idx_reg] = 1'b1;
                    occ_next                 = occ_reg + 1'b1;
                    arr_cnt_next             = arr_cnt_reg + 1'b1;
                    state_next               = spq_pkg::ST_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            spq_pkg::ST_SCAN:
            begin
                // Issue one slot read per cycle
                rd_live_next = valid_reg[scan_idx_reg];
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = spq_pkg::ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            spq_pkg::ST_DRAIN:
            begin
                state_next = spq_pkg::ST_REPLY;
            end

            spq_pkg::ST_REPLY:
            begin
                // Remove the winner and return it
                valid_next[best_idx_reg] = 1'b0;
                occ_next                 = occ_reg - 1'b1;
                done_next                = 1'b1;
                status_next              = spq_pkg::STATUS_SERVED;
                served_tag_next          = spq_pkg::PORT_TAG_W'(best_tag_reg);
                served_sev_next          = best_sev_reg;
                state_next               = spq_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != spq_pkg::ST_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign served_tag      = served_tag_reg;
    assign served_severity = served_sev_reg;

    // Occupancy tracks the number of set valid bits
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy out of step with valid bits");

    // A free slot search starts only with room left
    a_find_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::ST_FIND) |-> (occ_reg < FULL_OCC))
        else $error("free slot search on a full queue");

    // The reply always removes a live slot found by the scan
    a_reply_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::ST_REPLY) |-> (best_found_reg && valid_reg[best_idx_reg]))
        else $error("serve reply without a live winner");

    // A served result follows a scan, never a bare accept
    a_served_after_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == spq_pkg::STATUS_SERVED))
            |-> ($past(state_reg) == spq_pkg::ST_REPLY))
        else $error("served result without a completed scan");

endmodule
